>>> rtl/sin_pkg.sv
`timescale 1ns / 1ps
package sin_pkg;

    // index width and the sequence length width
    localparam int IW = 64;
    localparam int LW = IW - 1;

    localparam logic signed [IW-1:0] IMAX = {1'b0, {LW{1'b1}}};
    localparam logic signed [IW-1:0] IMIN = {1'b1, {LW{1'b0}}};

    // classified request passed from front to back
    typedef struct packed {
        logic signed [IW-1:0] start;
        logic signed [IW-1:0] stop;
        logic signed [IW-1:0] step;
        logic                 neg;
        logic                 zero;
    } t_item;

    // finished result
    typedef struct packed {
        logic signed [IW-1:0] start;
        logic signed [IW-1:0] stop;
        logic signed [IW-1:0] step;
        logic [LW-1:0]        count;
        logic                 status;
    } t_res;

    // one stage of the count divider
    typedef struct packed {
        t_item         item;
        logic          nonempty;
        logic [LW-1:0] rem;
        logic [LW-1:0] dq;
        logic [LW-1:0] dv;
    } t_stage;

endpackage

>>> rtl/sin_front.sv
`timescale 1ns / 1ps
module sin_front import sin_pkg::*; (
    input  logic signed [IW-1:0] i_start_value,
    input  logic                 i_start_absent,
    input  logic signed [IW-1:0] i_stop_value,
    input  logic                 i_stop_absent,
    input  logic signed [IW-1:0] i_step_value,
    input  logic                 i_step_absent,
    input  logic [LW-1:0]        i_seq_length,
    output t_item                o_item
);

    function automatic logic signed [IW-1:0] clamp_index(
        input logic signed [IW-1:0] x,
        input logic signed [IW-1:0] len,
        input logic                 neg
    );
        logic signed [IW-1:0] s;
        logic signed [IW-1:0] r;
        s = x + len;
        if (x[IW-1]) begin
            if (s[IW-1]) r = neg ? -'sd1 : '0;
            else         r = s;
        end else if (x >= len) begin
            r = neg ? len - 'sd1 : len;
        end else begin
            r = x;
        end
        return r;
    endfunction

    logic signed [IW-1:0] len;
    logic signed [IW-1:0] step_raw;
    logic signed [IW-1:0] step_eff;
    logic signed [IW-1:0] start_raw;
    logic signed [IW-1:0] stop_raw;
    logic                 neg;
    logic                 zero;

    // resolve step, direction and absent bounds
    always_comb begin
        len      = {1'b0, i_seq_length};
        step_raw = i_step_absent ? IW'(1) : i_step_value;
        zero     = (step_raw == '0);
        step_eff = (step_raw == IMIN) ? IMIN + IW'(1) : step_raw;
        neg      = step_eff[IW-1];
        start_raw = i_start_absent ? (neg ? IMAX : '0) : i_start_value;
        stop_raw  = i_stop_absent ? (neg ? IMIN : IMAX) : i_stop_value;
    end

    // clamp both bounds; a zero step reports all zeros
    always_comb begin
        o_item.neg  = neg;
        o_item.zero = zero;
        if (zero) begin
            o_item.start = '0;
            o_item.stop  = '0;
            o_item.step  = '0;
        end else begin
            o_item.start = clamp_index(start_raw, len, neg);
            o_item.stop  = clamp_index(stop_raw, len, neg);
            o_item.step  = step_eff;
        end
    end

endmodule

>>> rtl/sin_queue.sv
`timescale 1ns / 1ps
module sin_queue import sin_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_data,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_empty,
    output t_item o_data
);

    localparam int DEPTH = 4;
    localparam int AW    = $clog2(DEPTH);

    t_item           r_mem [DEPTH];
    logic [AW-1:0]   r_wr;
    logic [AW-1:0]   r_rd;
    logic [AW:0]     r_cnt;
    logic            do_push;
    logic            do_pop;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wr <= r_wr + AW'(1);
            if (do_pop)  r_rd <= r_rd + AW'(1);
            r_cnt <= r_cnt + (AW+1)'(do_push) - (AW+1)'(do_pop);
        end
    end

    // store request
    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr] <= i_data;
    end

endmodule

>>> rtl/sin_back.sv
`timescale 1ns / 1ps
module sin_back import sin_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_q_empty,
    input  t_item i_q_data,
    output logic  o_q_pop,
    input  logic  i_pop,
    output logic  o_empty,
    output t_res  o_res
);

    localparam int NST   = LW;
    localparam int ODEPTH = 4;
    localparam int OAW   = $clog2(ODEPTH);

    t_stage          r_st [NST+1];
    logic            r_v  [NST+1];
    t_stage          n_st [NST+1];
    logic            en;
    logic            ofull;

    t_res            r_omem [ODEPTH];
    logic [OAW-1:0]  r_owr;
    logic [OAW-1:0]  r_ord;
    logic [OAW:0]    r_ocnt;
    logic            opush;
    logic            opop;
    t_res            res;

    assign ofull   = (r_ocnt == (OAW+1)'(ODEPTH));
    assign o_empty = (r_ocnt == '0);
    assign en      = !(r_v[NST] && ofull);
    assign o_q_pop = en && !i_q_empty;
    assign opush   = en && r_v[NST];
    assign opop    = i_pop && !o_empty;
    assign o_res   = r_omem[r_ord];

    // form dividend and divisor from the clamped bounds, then
    // resolve one restoring quotient bit per stage
    always_comb begin
        logic signed [IW-1:0] diff;
        logic signed [IW-1:0] mag;
        logic [LW:0]          trial;
        n_st[0].item = i_q_data;
        n_st[0].rem  = '0;
        if (i_q_data.neg) begin
            n_st[0].nonempty = i_q_data.stop < i_q_data.start;
            diff = i_q_data.start - i_q_data.stop - IW'(1);
            mag  = -i_q_data.step;
        end else begin
            n_st[0].nonempty = i_q_data.start < i_q_data.stop;
            diff = i_q_data.stop - i_q_data.start - IW'(1);
            mag  = i_q_data.step;
        end
        n_st[0].dq = n_st[0].nonempty ? diff[LW-1:0] : '0;
        n_st[0].dv = mag[LW-1:0];

        for (int k = 0; k < NST; k++) begin
            n_st[k+1] = r_st[k];
            trial = {r_st[k].rem, r_st[k].dq[LW-1]} - {1'b0, r_st[k].dv};
            if (!trial[LW]) begin
                n_st[k+1].rem = trial[LW-1:0];
                n_st[k+1].dq  = {r_st[k].dq[LW-2:0], 1'b1};
            end else begin
                n_st[k+1].rem = {r_st[k].rem[LW-2:0], r_st[k].dq[LW-1]};
                n_st[k+1].dq  = {r_st[k].dq[LW-2:0], 1'b0};
            end
        end
    end

    // advance divider valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= NST; k++) r_v[k] <= 1'b0;
        end else if (en) begin
            r_v[0] <= !i_q_empty;
            for (int k = 0; k < NST; k++) r_v[k+1] <= r_v[k];
        end
    end

    // advance divider payload
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k <= NST; k++) r_st[k] <= n_st[k];
        end
    end

    // build the result from the last stage
    always_comb begin
        res.start  = r_st[NST].item.start;
        res.stop   = r_st[NST].item.stop;
        res.step   = r_st[NST].item.step;
        res.status = r_st[NST].item.zero;
        res.count  = r_st[NST].nonempty ? r_st[NST].dq + LW'(1) : '0;
    end

    // hold results until popped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owr  <= '0;
            r_ord  <= '0;
            r_ocnt <= '0;
        end else begin
            if (opush) r_owr <= r_owr + OAW'(1);
            if (opop)  r_ord <= r_ord + OAW'(1);
            r_ocnt <= r_ocnt + (OAW+1)'(opush) - (OAW+1)'(opop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (opush) r_omem[r_owr] <= res;
    end

    a_ocnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ocnt <= (OAW+1)'(ODEPTH))
        else $error("result queue overfilled");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[NST] && ofull && !opop) |=> r_v[NST] && $stable(r_st[NST]))
        else $error("stalled result lost");

    a_zero_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_res.status) |-> (o_res.count == '0 && o_res.step == '0))
        else $error("zero step result not cleared");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_q_pop && !i_q_empty) |=> r_v[0])
        else $error("popped request not entered into divider");

endmodule

>>> rtl/slice_index_normalizer_unit.sv
`timescale 1ns / 1ps
// Slice index normalizer: takes one slice request (start, stop, step with
// absent flags, and a sequence length) and returns the clamped start and
// stop, the effective step, the element count and a zero-step status. A new
// request is taken every cycle while the input queue is not full; each one
// passes through the 63-stage restoring divider that computes the element
// count, one quotient bit per stage, and the divider holds while the result
// queue is full. A four-entry queue sits between the classifying front and
// the divider, and another four-entry queue holds finished results until popped.
module slice_index_normalizer_unit import sin_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic signed [IW-1:0] i_start_value,
    input  logic                 i_start_absent,
    input  logic signed [IW-1:0] i_stop_value,
    input  logic                 i_stop_absent,
    input  logic signed [IW-1:0] i_step_value,
    input  logic                 i_step_absent,
    input  logic [LW-1:0]        i_seq_length,
    output logic                 empty,
    input  logic                 pop,
    output logic signed [IW-1:0] o_norm_start,
    output logic signed [IW-1:0] o_norm_stop,
    output logic signed [IW-1:0] o_norm_step,
    output logic [LW-1:0]        o_elem_count,
    output logic                 o_status
);

    t_item item;
    t_item q_data;
    logic  q_empty;
    logic  q_pop;
    t_res  res;

    sin_front u_front (
        .i_start_value  (i_start_value),
        .i_start_absent (i_start_absent),
        .i_stop_value   (i_stop_value),
        .i_stop_absent  (i_stop_absent),
        .i_step_value   (i_step_value),
        .i_step_absent  (i_step_absent),
        .i_seq_length   (i_seq_length),
        .o_item         (item)
    );

    sin_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (item),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_data)
    );

    sin_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_data  (q_data),
        .o_q_pop   (q_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_res     (res)
    );

    assign o_norm_start = res.start;
    assign o_norm_stop  = res.stop;
    assign o_norm_step  = res.step;
    assign o_elem_count = res.count;
    assign o_status     = res.status;

endmodule
